// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types, widths and helpers for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

   localparam int WORD_W  = 16;               // entry and component width
   localparam int FRAC_W  = WORD_W - 2;       // fraction bits, q1.f
   localparam int RAD_W   = WORD_W + 2;       // signed radicand
   localparam int DIFF_W  = WORD_W + 1;       // signed sum of two entries
   localparam int ROOT_W  = WORD_W - 1;       // square root result
   localparam int SQ_IN_W = 2 * ROOT_W;       // square root operand
   localparam int SQ_REM_W = ROOT_W + 2;      // square root remainder
   localparam int DIV_W   = ROOT_W + 2;       // divisor, four times the root
   localparam int MAG_W   = DIFF_W;           // magnitude of a difference
   localparam int DREM_W  = 2 * WORD_W + 1;   // division remainder

   localparam logic [1:0] BR_TRACE = 2'd0;
   localparam logic [1:0] BR_X     = 2'd1;
   localparam int         BR_Y_I   = 2;
   localparam logic [1:0] BR_Y     = 2'(BR_Y_I);
   localparam logic [1:0] BR_Z     = 2'd3;

   typedef struct packed {
      logic signed [WORD_W-1:0] m00;
      logic signed [WORD_W-1:0] m01;
      logic signed [WORD_W-1:0] m02;
      logic signed [WORD_W-1:0] m10;
      logic signed [WORD_W-1:0] m11;
      logic signed [WORD_W-1:0] m12;
      logic signed [WORD_W-1:0] m20;
      logic signed [WORD_W-1:0] m21;
      logic signed [WORD_W-1:0] m22;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] quat_w;
      logic signed [WORD_W-1:0] quat_x;
      logic signed [WORD_W-1:0] quat_y;
      logic signed [WORD_W-1:0] quat_z;
      logic [1:0]               branch_taken;
      logic                     degenerate;
   } rsp_type;

   // clamp an unsigned quotient and apply its sign
   function automatic logic [WORD_W-1:0] sat_quot(input logic [WORD_W-1:0] q,
                                                   input logic neg,
                                                   input logic ovf);
      logic big;
      big = ovf || q[WORD_W-1];
      if (neg) begin
         sat_quot = big ? {1'b1, {(WORD_W-1){1'b0}}} : WORD_W'(~q + 1'b1);
      end else begin
         sat_quot = big ? {1'b0, {(WORD_W-1){1'b1}}} : q;
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// shepperd conversion of a q1.14 rotation matrix to a unit quaternion
// ----------------------------------------------------------------------------
// usage:
//  - a word (nine matrix entries) is taken on req_word at a clock edge with
//    start high and busy low; busy never rises, so a word may come every cycle
//  - one result word per matrix appears on rsp_word for a single cycle with
//    rsp_strobe high; the receiver cannot stall, results are never held back
//  - 34 register stages: input register, 15 square root cells (one root
//    bit each), a divisor set-up stage, 16 divider cells (one quotient bit
//    each, three dividers side by side) and the output register; the input
//    register loads at the accepting edge
//  - throughput is one matrix per cycle, set by the cell chains: every cell
//    hands its partial result to its neighbour each cycle
//  - reset (synchronous) clears all valid flags; words in flight are dropped
//  - a non-positive radicand gives zero components and degenerate set
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  rmq_pkg::req_type req_word,
   output logic             rsp_strobe,
   output rmq_pkg::rsp_type rsp_word
);
   import rmq_pkg::*;

   localparam int SQ_SIDE_W = 3 + 3 * DIFF_W;      // branch, degenerate, diffs
   localparam int DV_SIDE_W = 3 + ROOT_W + 2;      // branch, degenerate, root, sign, ovf

   // input register
   logic    in_valid_ff;
   req_type in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start;
      end
      if (start) begin
         in_ff <= req_word;
      end
   end

   assign busy = 1'b0;

   // branch choice, radicand and the three off-diagonal sums or differences
   logic signed [RAD_W-1:0]  ea, eb, ec, tr, rad;
   logic signed [DIFF_W-1:0] d0, d1, d2;
   logic [1:0]               br;
   logic                     deg;
   logic [SQ_IN_W-1:0]       sq_operand;

   always_comb begin
      ea = RAD_W'(in_ff.m00);
      eb = RAD_W'(in_ff.m11);
      ec = RAD_W'(in_ff.m22);
      tr = ea + eb + ec;
      priority if (tr > 0) begin
         br  = BR_TRACE;
         rad = RAD_W'(1 << FRAC_W) + tr;
         d0  = DIFF_W'(in_ff.m21) - DIFF_W'(in_ff.m12);
         d1  = DIFF_W'(in_ff.m02) - DIFF_W'(in_ff.m20);
         d2  = DIFF_W'(in_ff.m10) - DIFF_W'(in_ff.m01);
      end else if (ea > eb && ea > ec) begin
         br  = BR_X;
         rad = RAD_W'(1 << FRAC_W) + ea - eb - ec;
         d0  = DIFF_W'(in_ff.m21) - DIFF_W'(in_ff.m12);
         d1  = DIFF_W'(in_ff.m01) + DIFF_W'(in_ff.m10);
         d2  = DIFF_W'(in_ff.m02) + DIFF_W'(in_ff.m20);
      end else if (eb > ec) begin
         br  = BR_Y;
         rad = RAD_W'(1 << FRAC_W) + eb - ea - ec;
         d0  = DIFF_W'(in_ff.m02) - DIFF_W'(in_ff.m20);
         d1  = DIFF_W'(in_ff.m01) + DIFF_W'(in_ff.m10);
         d2  = DIFF_W'(in_ff.m21) + DIFF_W'(in_ff.m12);
      end else begin
         br  = BR_Z;
         rad = RAD_W'(1 << FRAC_W) + ec - ea - eb;
         d0  = DIFF_W'(in_ff.m10) - DIFF_W'(in_ff.m01);
         d1  = DIFF_W'(in_ff.m02) + DIFF_W'(in_ff.m20);
         d2  = DIFF_W'(in_ff.m21) + DIFF_W'(in_ff.m12);
      end
      deg = !(rad > 0);
      // radicand scaled by 2^(f-2); zero when degenerate
      sq_operand = deg ? '0 : SQ_IN_W'(rad) << (FRAC_W - 2);
   end

   // square root chain
   logic                sq_valid [ROOT_W+1];
   logic [SQ_REM_W-1:0] sq_rem   [ROOT_W+1];
   logic [ROOT_W-1:0]   sq_root  [ROOT_W+1];
   logic [SQ_IN_W-1:0]  sq_rad   [ROOT_W+1];
   logic [SQ_SIDE_W-1:0] sq_side [ROOT_W+1];

   assign sq_valid[0] = in_valid_ff;
   assign sq_rem[0]   = '0;
   assign sq_root[0]  = '0;
   assign sq_rad[0]   = sq_operand;
   assign sq_side[0]  = {br, deg, d0, d1, d2};

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      rmq_sqrt_cell #(.SIDE_W(SQ_SIDE_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .in_rad    (sq_rad[i]),
         .in_side   (sq_side[i]),
         .out_valid (sq_valid[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1]),
         .out_rad   (sq_rad[i+1]),
         .out_side  (sq_side[i+1])
      );
   end

   // divisor set-up: magnitudes, signs and the overflow check per lane
   logic [1:0]               sq_br;
   logic                     sq_deg;
   logic signed [DIFF_W-1:0] sq_d [3];
   logic [DIV_W-1:0]         divisor;
   logic [DREM_W-1:0]        div_top;
   logic [MAG_W-1:0]         mag   [3];
   logic [DREM_W-1:0]        num_in [3];
   logic [2:0]               neg_in, ovf_in;

   always_comb begin
      {sq_br, sq_deg, sq_d[0], sq_d[1], sq_d[2]} = sq_side[ROOT_W];
      divisor = {sq_root[ROOT_W], 2'b00};
      div_top = DREM_W'(divisor) << WORD_W;
      for (int k = 0; k < 3; k++) begin
         neg_in[k] = sq_d[k][DIFF_W-1];
         mag[k]    = neg_in[k] ? MAG_W'(~sq_d[k] + 1'b1) : MAG_W'(sq_d[k]);
         num_in[k] = DREM_W'(mag[k]) << FRAC_W;
         ovf_in[k] = num_in[k] >= div_top;
      end
   end

   logic              pr_valid_ff;
   logic [DREM_W-1:0] pr_num_ff [3];
   logic [DIV_W-1:0]  pr_div_ff;
   logic [2:0]        pr_neg_ff, pr_ovf_ff;
   logic [ROOT_W-1:0] pr_root_ff;
   logic [1:0]        pr_br_ff;
   logic              pr_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_valid_ff <= 1'b0;
      end else begin
         pr_valid_ff <= sq_valid[ROOT_W];
      end
      pr_num_ff  <= num_in;
      pr_div_ff  <= divisor;
      pr_neg_ff  <= neg_in;
      pr_ovf_ff  <= ovf_in;
      pr_root_ff <= sq_root[ROOT_W];
      pr_br_ff   <= sq_br;
      pr_deg_ff  <= sq_deg;
   end

   // three divider chains side by side, most significant quotient bit first
   logic                 dv_valid [3][WORD_W+1];
   logic [DREM_W-1:0]    dv_rem   [3][WORD_W+1];
   logic [DIV_W-1:0]     dv_div   [3][WORD_W+1];
   logic [WORD_W-1:0]    dv_quot  [3][WORD_W+1];
   logic [DV_SIDE_W-1:0] dv_side  [3][WORD_W+1];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      assign dv_valid[k][0] = pr_valid_ff;
      assign dv_rem[k][0]   = pr_num_ff[k];
      assign dv_div[k][0]   = pr_div_ff;
      assign dv_quot[k][0]  = '0;
      assign dv_side[k][0]  = {pr_br_ff, pr_deg_ff, pr_root_ff, pr_neg_ff[k], pr_ovf_ff[k]};

      for (genvar j = 0; j < WORD_W; j++) begin : g_bit
         rmq_div_cell #(.SHIFT(WORD_W - 1 - j), .SIDE_W(DV_SIDE_W)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (dv_valid[k][j]),
            .in_rem    (dv_rem[k][j]),
            .in_div    (dv_div[k][j]),
            .in_quot   (dv_quot[k][j]),
            .in_side   (dv_side[k][j]),
            .out_valid (dv_valid[k][j+1]),
            .out_rem   (dv_rem[k][j+1]),
            .out_div   (dv_div[k][j+1]),
            .out_quot  (dv_quot[k][j+1]),
            .out_side  (dv_side[k][j+1])
         );
      end
   end

   // assembly: the branch's own component is the root, the rest in order
   logic [1:0]        fin_br;
   logic              fin_deg;
   logic [ROOT_W-1:0] fin_root;
   logic [WORD_W-1:0] own;
   logic [WORD_W-1:0] oth [3];
   logic [1:0]        fin_sign [3];
   rsp_type           rsp_in, rsp_ff;
   logic              strobe_ff;

   always_comb begin
      {fin_br, fin_deg, fin_root, fin_sign[0]} = dv_side[0][WORD_W];
      fin_sign[1] = dv_side[1][WORD_W][1:0];
      fin_sign[2] = dv_side[2][WORD_W][1:0];
      own = WORD_W'(fin_root);
      for (int k = 0; k < 3; k++) begin
         oth[k] = sat_quot(dv_quot[k][WORD_W], fin_sign[k][1], fin_sign[k][0]);
      end
      unique case (fin_br)
         BR_TRACE: {rsp_in.quat_w, rsp_in.quat_x, rsp_in.quat_y, rsp_in.quat_z} =
                   {own, oth[0], oth[1], oth[2]};
         BR_X:     {rsp_in.quat_w, rsp_in.quat_x, rsp_in.quat_y, rsp_in.quat_z} =
                   {oth[0], own, oth[1], oth[2]};
         BR_Y:     {rsp_in.quat_w, rsp_in.quat_x, rsp_in.quat_y, rsp_in.quat_z} =
                   {oth[0], oth[1], own, oth[2]};
         default:  {rsp_in.quat_w, rsp_in.quat_x, rsp_in.quat_y, rsp_in.quat_z} =
                   {oth[0], oth[1], oth[2], own};
      endcase
      if (fin_deg) begin
         rsp_in.quat_w = '0;
         rsp_in.quat_x = '0;
         rsp_in.quat_y = '0;
         rsp_in.quat_z = '0;
      end
      rsp_in.branch_taken = fin_br;
      rsp_in.degenerate   = fin_deg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid[0][WORD_W];
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// one digit of a restoring square root, registered, with a carried side word
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_cell #(
   parameter int SIDE_W = 1
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          in_valid,
   input  wire [rmq_pkg::SQ_REM_W-1:0]  in_rem,
   input  wire [rmq_pkg::ROOT_W-1:0]    in_root,
   input  wire [rmq_pkg::SQ_IN_W-1:0]   in_rad,
   input  wire [SIDE_W-1:0]             in_side,
   output logic                         out_valid,
   output logic [rmq_pkg::SQ_REM_W-1:0] out_rem,
   output logic [rmq_pkg::ROOT_W-1:0]   out_root,
   output logic [rmq_pkg::SQ_IN_W-1:0]  out_rad,
   output logic [SIDE_W-1:0]            out_side
);
   import rmq_pkg::*;

   logic                valid_ff;
   logic [SQ_REM_W-1:0] trial;
   logic [SQ_REM_W-1:0] sub;
   logic                ge;
   logic [SQ_REM_W-1:0] rem_in, rem_ff;
   logic [ROOT_W-1:0]   root_in, root_ff;
   logic [SQ_IN_W-1:0]  rad_ff;
   logic [SIDE_W-1:0]   side_ff;

   always_comb begin
      trial   = {in_rem[SQ_REM_W-3:0], in_rad[SQ_IN_W-1 -: 2]};
      sub     = {in_root, 2'b01};
      ge      = trial >= sub;
      rem_in  = ge ? trial - sub : trial;
      root_in = {in_root[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= {in_rad[SQ_IN_W-3:0], 2'b00};
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_rad   = rad_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== sv/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell
// one quotient bit of a restoring divider, registered, with a carried side word
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_cell #(
   parameter int SHIFT  = 0,
   parameter int SIDE_W = 1
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        in_valid,
   input  wire [rmq_pkg::DREM_W-1:0]  in_rem,
   input  wire [rmq_pkg::DIV_W-1:0]   in_div,
   input  wire [rmq_pkg::WORD_W-1:0]  in_quot,
   input  wire [SIDE_W-1:0]           in_side,
   output logic                       out_valid,
   output logic [rmq_pkg::DREM_W-1:0] out_rem,
   output logic [rmq_pkg::DIV_W-1:0]  out_div,
   output logic [rmq_pkg::WORD_W-1:0] out_quot,
   output logic [SIDE_W-1:0]          out_side
);
   import rmq_pkg::*;

   logic              valid_ff;
   logic [DREM_W-1:0] dsh;
   logic              ge;
   logic [DREM_W-1:0] rem_in, rem_ff;
   logic [WORD_W-1:0] quot_in, quot_ff;
   logic [DIV_W-1:0]  div_ff;
   logic [SIDE_W-1:0] side_ff;

   always_comb begin
      dsh            = DREM_W'(in_div) << SHIFT;
      ge             = in_rem >= dsh;
      rem_in         = ge ? in_rem - dsh : in_rem;
      quot_in        = in_quot;
      quot_in[SHIFT] = ge;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= in_div;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;
   assign out_quot  = quot_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

// ===== tb/rotation_matrix_to_quaternion_test.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// checks the matrix to quaternion block against a bit-true predictor, using
// a directed table of matrices followed by random and near-rotation words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_test;
   import rmq_pkg::*;

   localparam int ONE_Q      = 1 << FRAC_W;
   localparam int LATENCY    = 34;
   localparam int N_RANDOM   = 2000;
   localparam int CYCLE_CAP  = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   rotation_matrix_to_quaternion dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #2 clock = ~clock;

   rsp_type quat_queue[$];   // expected quaternions, oldest first
   int      mismatches = 0;
   int      cycles = 0;

   // square root by the bitwise method, floor
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v >>= 2;
      while (bit_v != 0) begin
         if (n >= res + bit_v) begin
            n -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   function automatic logic [WORD_W-1:0] clamp_word(input longint v);
      longint hi, lo;
      hi = (64'sd1 <<< (WORD_W - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[WORD_W-1:0];
   endfunction

   // (d << f) / (4 m), truncated toward zero, saturated
   function automatic logic [WORD_W-1:0] scaled_ratio(input longint d,
                                                      input longint unsigned m);
      longint unsigned mag, q;
      logic neg;
      neg = d < 0;
      mag = neg ? -d : d;
      q = (mag << FRAC_W) / (4 * m);
      if (q > (64'd1 << (WORD_W - 1))) q = 64'd1 << (WORD_W - 1);
      return clamp_word(neg ? -longint'(q) : longint'(q));
   endfunction

   function automatic rsp_type predict_quat(input req_type m);
      rsp_type r;
      longint a, b, c, rad, d0, d1, d2;
      longint unsigned root;
      logic [WORD_W-1:0] o0, o1, o2, mc;
      a = m.m00; b = m.m11; c = m.m22;
      r = '0;
      if (a + b + c > 0) begin
         r.branch_taken = BR_TRACE; rad = ONE_Q + a + b + c;
         d0 = m.m21 - m.m12; d1 = m.m02 - m.m20; d2 = m.m10 - m.m01;
      end else if (a > b && a > c) begin
         r.branch_taken = BR_X; rad = ONE_Q + a - b - c;
         d0 = m.m21 - m.m12; d1 = m.m01 + m.m10; d2 = m.m02 + m.m20;
      end else if (b > c) begin
         r.branch_taken = BR_Y; rad = ONE_Q + b - a - c;
         d0 = m.m02 - m.m20; d1 = m.m01 + m.m10; d2 = m.m21 + m.m12;
      end else begin
         r.branch_taken = BR_Z; rad = ONE_Q + c - a - b;
         d0 = m.m10 - m.m01; d1 = m.m02 + m.m20; d2 = m.m21 + m.m12;
      end
      r.degenerate = rad <= 0;
      if (rad > 0) begin
         root = int_sqrt(longint'(rad) << (FRAC_W - 2));
         mc = clamp_word(longint'(root));
         o0 = scaled_ratio(d0, root);
         o1 = scaled_ratio(d1, root);
         o2 = scaled_ratio(d2, root);
         // the branch's own component sits at its index, the others fill in order
         unique case (r.branch_taken)
            BR_TRACE: begin r.quat_w = mc; r.quat_x = o0; r.quat_y = o1; r.quat_z = o2; end
            BR_X:     begin r.quat_w = o0; r.quat_x = mc; r.quat_y = o1; r.quat_z = o2; end
            BR_Y:     begin r.quat_w = o0; r.quat_x = o1; r.quat_y = mc; r.quat_z = o2; end
            default:  begin r.quat_w = o0; r.quat_x = o1; r.quat_y = o2; r.quat_z = mc; end
         endcase
      end
      return r;
   endfunction

   // directed table; expected only where obvious, else predictor
   typedef struct {
      req_type mat;
      logic    typed;
      rsp_type quat;
   } dir_row_type;

   dir_row_type dir_table[$];

   function automatic req_type diag_mat(input int a, input int b, input int c);
      req_type m;
      m = '0;
      m.m00 = WORD_W'(a); m.m11 = WORD_W'(b); m.m22 = WORD_W'(c);
      return m;
   endfunction

   function automatic req_type rand_mat();
      req_type m;
      logic [5*32-1:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
      m = raw[$bits(req_type)-1:0];
      return m;
   endfunction

   // near-rotation: entries in [-1, 1], with one random diagonal entry (or none) held at one
   function automatic req_type near_rot();
      req_type m;
      int s;
      m = '0;
      s = $urandom_range(0, 3);
      m.m00 = WORD_W'((s == 1) ? ONE_Q : -ONE_Q + int'($urandom_range(0, 2 * ONE_Q)));
      m.m11 = WORD_W'((s == 2) ? ONE_Q : -ONE_Q + int'($urandom_range(0, 2 * ONE_Q)));
      m.m22 = WORD_W'((s == 3) ? ONE_Q : -ONE_Q + int'($urandom_range(0, 2 * ONE_Q)));
      m.m01 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m02 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m10 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m12 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m20 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      m.m21 = WORD_W'(int'($urandom_range(0, 2 * ONE_Q)) - ONE_Q);
      return m;
   endfunction

   task automatic add_row(input req_type m, input logic typed, input rsp_type q);
      dir_row_type row;
      row.mat = m; row.typed = typed; row.quat = q;
      dir_table.push_back(row);
   endtask

   task automatic build_table();
      rsp_type q;
      req_type m;
      // identity: w = 1, rest zero
      q = '0; q.quat_w = WORD_W'(ONE_Q); q.branch_taken = BR_TRACE;
      add_row(diag_mat(ONE_Q, ONE_Q, ONE_Q), 1'b1, q);
      // zero matrix: trace not positive, tie goes to z, radicand one
      q = '0; q.quat_z = WORD_W'(ONE_Q / 2); q.branch_taken = BR_Z;
      add_row(diag_mat(0, 0, 0), 1'b1, q);
      // half-turn about x, y, z
      add_row(diag_mat(ONE_Q, -ONE_Q, -ONE_Q), 1'b0, q);
      add_row(diag_mat(-ONE_Q, ONE_Q, -ONE_Q), 1'b0, q);
      add_row(diag_mat(-ONE_Q, -ONE_Q, ONE_Q), 1'b0, q);
      // strongly negative diagonals, in the x and z branches
      add_row(diag_mat(-32768, -32768, -32768), 1'b0, q);
      add_row(diag_mat(-16384, -32768, 16383), 1'b0, q);
      add_row(diag_mat(-32768, -16384, 16383), 1'b0, q);
      add_row(diag_mat(16383, -32768, -16384), 1'b0, q);
      // ties on the diagonal
      add_row(diag_mat(-100, -100, -200), 1'b0, q);
      add_row(diag_mat(-100, -200, -100), 1'b0, q);
      // extremes of every field
      m = {9{16'h7fff}}; add_row(m, 1'b0, q);
      m = {9{16'h8000}}; add_row(m, 1'b0, q);
      m = {16'h7fff, {7{16'h8000}}, 16'h7fff}; add_row(m, 1'b0, q);
      m = {16'h8000, {7{16'h7fff}}, 16'h8000}; add_row(m, 1'b0, q);
      // small radicand with large off-diagonals saturates the quotients
      m = {16'h0000, 16'h7fff, 16'h8000, 16'h8000, 16'h0000,
           16'h7fff, 16'h7fff, 16'h8000, 16'h0001};
      add_row(m, 1'b0, q);
      m = {16'h0001, 16'h8000, 16'h8000, 16'h8000, 16'h0000,
           16'h8000, 16'h8000, 16'h8000, 16'h0000};
      add_row(m, 1'b0, q);
      m = {16'hc000, 16'h7fff, 16'h7fff, 16'h7fff, 16'hc001,
           16'h7fff, 16'h7fff, 16'h7fff, 16'hc000};
      add_row(m, 1'b0, q);
   endtask

   // sender: bursts and gaps, one word per accepted cycle
   task automatic send_word(input req_type m, input logic typed, input rsp_type q);
      req_word <= m;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      quat_queue.push_back(typed ? q : predict_quat(m));
   endtask

   int burst_left = 0;

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   // receiver: always takes a strobed result word
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (quat_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", rsp_word);
         end else begin
            want = quat_queue.pop_front();
            if (rsp_word !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h %h %h %h br %0d dg %b, got %h %h %h %h br %0d dg %b",
                           want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                           want.branch_taken, want.degenerate,
                           rsp_word.quat_w, rsp_word.quat_x, rsp_word.quat_y,
                           rsp_word.quat_z, rsp_word.branch_taken, rsp_word.degenerate);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      build_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_table[i]) begin
         pace();
         send_word(dir_table[i].mat, dir_table[i].typed, dir_table[i].quat);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         pace();
         // mostly plausible rotations, some raw bit patterns
         send_word(($urandom_range(0, 3) == 0) ? rand_mat() : near_rot(), 1'b0, none);
      end
      start <= 1'b0;
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== rotation_matrix_to_quaternion.f =====
sv/rmq_pkg.sv
sv/rmq_sqrt_cell.sv
sv/rmq_div_cell.sv
sv/rotation_matrix_to_quaternion.sv
tb/rotation_matrix_to_quaternion_test.sv
